// ===== rtl/mmd_pkg.sv =====
package mmd_pkg;

	localparam int unsigned CNT_W    = 25;
	localparam int unsigned POS_W    = 24;
	localparam int unsigned COL_W    = 11;
	localparam int unsigned NUM_W    = 10;
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned CTR_W    = 12;
	localparam int unsigned SCALE_W  = 11;
	localparam int unsigned Y_W      = 14;
	localparam int unsigned IDX_W    = 2;

	localparam logic [IDX_W-1:0] REG_SAMPLE_COUNT   = 2'd0;
	localparam logic [IDX_W-1:0] REG_COLUMN_COUNT   = 2'd1;
	localparam logic [IDX_W-1:0] REG_CENTRE_Y       = 2'd2;
	localparam logic [IDX_W-1:0] REG_VERTICAL_SCALE = 2'd3;

	localparam logic [CNT_W-1:0] N_MIN = 25'd16;
	localparam logic [CNT_W-1:0] N_MAX = 25'h1000000;
	localparam logic [COL_W-1:0] W_MAX = 11'd1024;

	function automatic logic [CNT_W-1:0] eff_n(input logic [CNT_W-1:0] n);
		logic [CNT_W-1:0] r;
		r = n;
		if (n < N_MIN) r = N_MIN;
		if (n > N_MAX) r = N_MAX;
		return r;
	endfunction

	function automatic logic [COL_W-1:0] eff_w(input logic [COL_W-1:0] w);
		logic [COL_W-1:0] r;
		r = w;
		if (w == '0) r = 11'd1;
		if (w > W_MAX) r = W_MAX;
		return r;
	endfunction

endpackage

// ===== rtl/mmd_div.sv =====
// restoring divider, one quotient bit per cycle
module mmd_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [mmd_pkg::CNT_W-1:0]       dividend,
	input  logic [mmd_pkg::COL_W-1:0]       divisor,
	output logic                            done,
	output logic [mmd_pkg::CNT_W-1:0]       quotient,
	output logic [mmd_pkg::COL_W-1:0]       remainder
);

	localparam logic [4:0] LAST_STEP = 5'(mmd_pkg::CNT_W - 1);

	logic                        busy_q;
	logic                        done_q;
	logic [4:0]                  cnt_q;
	logic [mmd_pkg::CNT_W-1:0]   dvd_q;
	logic [mmd_pkg::COL_W-1:0]   rem_q;
	logic [mmd_pkg::COL_W-1:0]   dsr_q;
	logic [mmd_pkg::COL_W:0]     trial;
	logic [mmd_pkg::COL_W:0]     diff;
	logic                        ge;

	assign trial = {rem_q, dvd_q[mmd_pkg::CNT_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[mmd_pkg::COL_W-1:0] : trial[mmd_pkg::COL_W-1:0];
			dvd_q <= {dvd_q[mmd_pkg::CNT_W-2:0], ge};
		end
	end

	assign done      = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

endmodule

// ===== rtl/mmd_row.sv =====
// shared scale multiplier; row = centre - round_half_up(s*scale / 32768)
module mmd_row (
	input  logic                                clk,
	input  logic                                load,
	input  logic signed [mmd_pkg::SAMPLE_W-1:0] sample,
	input  logic [mmd_pkg::SCALE_W-1:0]         scale,
	input  logic [mmd_pkg::CTR_W-1:0]           centre,
	output logic signed [mmd_pkg::Y_W-1:0]      y
);

	logic signed [27:0] a;
	logic signed [27:0] b;
	logic signed [27:0] prod_q;
	logic signed [27:0] rnd;
	logic signed [12:0] q;

	assign a = {{12{sample[mmd_pkg::SAMPLE_W-1]}}, sample};
	assign b = {17'd0, scale};

	always_ff @(posedge clk) begin
		if (load) prod_q <= a * b;
	end

	assign rnd = prod_q + 28'sd16384;
	assign q   = rnd[27:15];
	assign y   = $signed({2'b00, centre}) - $signed({q[12], q});

endmodule

// ===== rtl/waveform_min_max_decimator.sv =====
// Min/max peak decimator for waveform display.
// Input channel in_valid/in_ready carries one signed Q1.15 sample per beat.
// Output channel out_valid/out_ready carries one beat per closed column:
// column number, min, max, pixel rows for max and min, and a last-column flag.
// Config channel cfg_valid/cfg_ready (always ready) writes cfg_data into the
// register chosen by cfg_index; any write restarts the frame and recomputes
// N/W with a serial divider, during which no sample is taken.
// Reset loads the register defaults and runs the same divide.
// A sample that closes no column goes through the bin check only; each column
// it closes adds a bin check, two passes through the shared scale multiplier
// and an output load. Column bounds advance by one add and compare per column.
// The output register holds a beat while the receiver stalls; the block keeps
// working until it needs to load the next result, then waits for out_ready.
// A new sample is taken while a previous result still waits at the output.
module waveform_min_max_decimator (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [mmd_pkg::IDX_W-1:0]             cfg_index,
	input  logic [mmd_pkg::CNT_W-1:0]             cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [mmd_pkg::SAMPLE_W-1:0]   sample_value,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [mmd_pkg::NUM_W-1:0]             column_number,
	output logic signed [mmd_pkg::SAMPLE_W-1:0]   column_min,
	output logic signed [mmd_pkg::SAMPLE_W-1:0]   column_max,
	output logic signed [mmd_pkg::Y_W-1:0]        y_upper,
	output logic signed [mmd_pkg::Y_W-1:0]        y_lower,
	output logic                                  last_column
);

	localparam logic [2:0] ST_DIVGO   = 3'd0;
	localparam logic [2:0] ST_DIVWAIT = 3'd1;
	localparam logic [2:0] ST_IDLE    = 3'd2;
	localparam logic [2:0] ST_CHECK   = 3'd3;
	localparam logic [2:0] ST_ROWMAX  = 3'd4;
	localparam logic [2:0] ST_ROWMIN  = 3'd5;
	localparam logic [2:0] ST_EMIT    = 3'd6;

	localparam int unsigned CW = mmd_pkg::CNT_W;
	localparam int unsigned WW = mmd_pkg::COL_W;

	logic [2:0]                            state_q;
	logic [CW-1:0]                         sample_count_q;
	logic [WW-1:0]                         column_count_q;
	logic [mmd_pkg::CTR_W-1:0]             centre_y_q;
	logic [mmd_pkg::SCALE_W-1:0]           vertical_scale_q;

	logic [mmd_pkg::POS_W-1:0]             pos_q;
	logic [WW-1:0]                         cur_q;
	logic [CW-1:0]                         cs_q;
	logic [CW-1:0]                         ns_q;
	logic [WW-1:0]                         nr_q;
	logic signed [mmd_pkg::SAMPLE_W-1:0]   min_q;
	logic signed [mmd_pkg::SAMPLE_W-1:0]   max_q;
	logic signed [mmd_pkg::SAMPLE_W-1:0]   s_q;
	logic                                  open_q;
	logic signed [mmd_pkg::Y_W-1:0]        yup_q;

	logic                                  out_valid_q;
	logic [mmd_pkg::NUM_W-1:0]             out_col_q;
	logic signed [mmd_pkg::SAMPLE_W-1:0]   out_min_q;
	logic signed [mmd_pkg::SAMPLE_W-1:0]   out_max_q;
	logic signed [mmd_pkg::Y_W-1:0]        out_yup_q;
	logic signed [mmd_pkg::Y_W-1:0]        out_ylo_q;
	logic                                  out_last_q;

	logic [CW-1:0]                         n_eff;
	logic [WW-1:0]                         w_eff;
	logic [mmd_pkg::SCALE_W-1:0]           scale_eff;
	logic                                  div_start;
	logic                                  div_done;
	logic [CW-1:0]                         q0;
	logic [WW-1:0]                         r0;
	logic                                  row_load;
	logic signed [mmd_pkg::SAMPLE_W-1:0]   row_in;
	logic signed [mmd_pkg::Y_W-1:0]        row_y;

	logic                                  cfg_fire;
	logic                                  in_fire;
	logic                                  out_free;
	logic                                  emit_fire;
	logic [CW-1:0]                         pos_inc;
	logic [CW-1:0]                         bin_end;
	logic                                  close;
	logic [WW-1:0]                         cur_inc;
	logic [WW:0]                           nr_sum;
	logic [WW:0]                           nr_sub;
	logic                                  carry;
	logic                                  first;

	assign n_eff     = mmd_pkg::eff_n(sample_count_q);
	assign w_eff     = mmd_pkg::eff_w(column_count_q);
	assign scale_eff = (vertical_scale_q == '0) ? 11'd1 : vertical_scale_q;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign emit_fire = (state_q == ST_EMIT) && out_free;
	assign div_start = (state_q == ST_DIVGO);

	assign pos_inc = {1'b0, pos_q} + 25'd1;
	assign bin_end = (ns_q > cs_q) ? ns_q : cs_q + 25'd1;
	assign close   = (pos_inc >= bin_end) && (cur_q < w_eff);
	assign cur_inc = cur_q + 11'd1;
	assign nr_sum  = {1'b0, nr_q} + {1'b0, r0};
	assign carry   = nr_sum >= {1'b0, w_eff};
	assign nr_sub  = nr_sum - {1'b0, w_eff};
	assign first   = (pos_q == '0) || !open_q;

	assign row_load = (state_q == ST_ROWMAX) || (state_q == ST_ROWMIN);
	assign row_in   = (state_q == ST_ROWMAX) ? max_q : min_q;

	mmd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (n_eff),
		.divisor   (w_eff),
		.done      (div_done),
		.quotient  (q0),
		.remainder (r0)
	);

	mmd_row u_row (
		.clk    (clk),
		.load   (row_load),
		.sample (row_in),
		.scale  (scale_eff),
		.centre (centre_y_q),
		.y      (row_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_DIVGO;
			sample_count_q   <= 25'd16;
			column_count_q   <= 11'd1;
			centre_y_q       <= '0;
			vertical_scale_q <= 11'd1;
			pos_q            <= '0;
			cur_q            <= '0;
			open_q           <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			if (emit_fire) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;

			if (cfg_fire) begin
				case (cfg_index)
					mmd_pkg::REG_SAMPLE_COUNT:   sample_count_q   <= cfg_data;
					mmd_pkg::REG_COLUMN_COUNT:   column_count_q   <= cfg_data[WW-1:0];
					mmd_pkg::REG_CENTRE_Y:       centre_y_q       <= cfg_data[mmd_pkg::CTR_W-1:0];
					mmd_pkg::REG_VERTICAL_SCALE:
						vertical_scale_q <= cfg_data[mmd_pkg::SCALE_W-1:0];
					default: ;
				endcase
				state_q <= ST_DIVGO;
				pos_q   <= '0;
				cur_q   <= '0;
				open_q  <= 1'b0;
			end else begin
				case (state_q)
					ST_DIVGO:   state_q <= ST_DIVWAIT;
					ST_DIVWAIT: if (div_done) state_q <= ST_IDLE;
					ST_IDLE: begin
						if (in_fire) begin
							if (pos_q == '0) cur_q <= '0;
							open_q  <= 1'b1;
							state_q <= ST_CHECK;
						end
					end
					ST_CHECK: begin
						if (close) begin
							state_q <= ST_ROWMAX;
						end else begin
							pos_q   <= (pos_inc >= n_eff) ? '0 : pos_inc[mmd_pkg::POS_W-1:0];
							state_q <= ST_IDLE;
						end
					end
					ST_ROWMAX: state_q <= ST_ROWMIN;
					ST_ROWMIN: state_q <= ST_EMIT;
					ST_EMIT: begin
						if (out_free) begin
							cur_q <= cur_inc;
							if (cur_inc >= w_eff) open_q <= 1'b0;
							else open_q <= (ns_q <= {1'b0, pos_q});
							state_q <= ST_CHECK;
						end
					end
					default: state_q <= ST_DIVGO;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			s_q   <= sample_value;
			min_q <= (first || sample_value < min_q) ? sample_value : min_q;
			max_q <= (first || sample_value > max_q) ? sample_value : max_q;
			if (pos_q == '0) begin
				cs_q <= '0;
				ns_q <= q0;
				nr_q <= r0;
			end
		end
		if (state_q == ST_ROWMIN) yup_q <= row_y;
		if (emit_fire) begin
			out_col_q  <= cur_q[mmd_pkg::NUM_W-1:0];
			out_min_q  <= min_q;
			out_max_q  <= max_q;
			out_yup_q  <= yup_q;
			out_ylo_q  <= row_y;
			out_last_q <= (cur_inc == w_eff);
			if (cur_inc < w_eff) begin
				cs_q <= ns_q;
				ns_q <= ns_q + q0 + {24'd0, carry};
				nr_q <= carry ? nr_sub[WW-1:0] : nr_sum[WW-1:0];
				if (ns_q <= {1'b0, pos_q}) begin
					min_q <= s_q;
					max_q <= s_q;
				end
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign column_number = out_col_q;
	assign column_min    = out_min_q;
	assign column_max    = out_max_q;
	assign y_upper       = out_yup_q;
	assign y_lower       = out_ylo_q;
	assign last_column   = out_last_q;

endmodule
